// ===== rtl/tension_alarm_adaptive_baseline_top_macros.svh =====
// Assertion macros for the port-level checker of the tension alarm block.
`ifndef TENSION_ALARM_ADAPTIVE_BASELINE_TOP_MACROS_SVH
`define TENSION_ALARM_ADAPTIVE_BASELINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAAB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked in every cycle, reset included.
`define TAAB_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/taab_pkg.sv =====
// Shared types and constants of the tension alarm with adaptive baseline.
`default_nettype none

package taab_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_START  = 2'd2
    } t_cmd;

    // Operating phase.
    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_CALIB = 2'd1,
        PH_CHECK = 2'd2
    } t_phase;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_MARGIN = 2'd0,
        CFG_DRIFT_PAIRS  = 2'd1,
        CFG_HOLD_TICKS   = 2'd2
    } t_cfg_idx;

    // Configuration field widths and reset values.
    localparam int          MARGIN_W         = 8;
    localparam int          PAIRS_W          = 8;
    localparam int          HOLD_W           = 16;
    localparam logic [7:0]  MARGIN_RESET     = 8'd50;
    localparam logic [7:0]  PAIRS_RESET      = 8'd8;
    localparam logic [15:0] HOLD_RESET       = 16'd100;

    // Calibration uses 32 points, so the count is 5 bits and the sum shifts by 5.
    localparam int         CALIB_CNT_W = 5;
    localparam logic [4:0] CALIB_LAST  = 5'd31;

    // Four samples per point.
    localparam int         GROUP_SHIFT = 2;
    localparam logic [1:0] GROUP_LAST  = 2'd3;

    // Four consecutive excursions raise the alarm.
    localparam logic [3:0] HIST_ALL_OUT = 4'hF;
    localparam logic [3:0] HIST_ALL_IN  = 4'h0;

    // Strobes from the front end to the baseline tracker.
    typedef struct packed {
        logic point_chk;  // a point arrived in the check phase
        logic load_base;  // calibration finished, load the averaged baseline
        logic tick;       // timer tick
    } t_trk_ctl;

endpackage

`default_nettype wire

// ===== rtl/tension_alarm_adaptive_baseline_top.sv =====
// Top level of the tension alarm with adaptive baseline tracking.
// A result is valid in the cycle after its input transaction is accepted.
// One transaction per cycle while the receiver takes each result; an item goes straight into the result register.
// Input is taken when the result register is empty or its result is taken that cycle.
// Reset (synchronous, active low): all state but the result payload clears, phase returns to
// waiting, and the configuration registers load margin 50, drift pairs 8 and hold ticks 100.
`default_nettype none

module tension_alarm_adaptive_baseline_top #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_command,
    input  wire logic [SAMPLE_BITS-1:0]             i_sample_value,
    // Result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_point_valid,
    output logic [SAMPLE_BITS-1:0]                  o_point_value,
    output logic [1:0]                              o_phase,
    output logic                                    o_alarm,
    output logic [SAMPLE_BITS-1:0]                  o_baseline,
    output logic [SAMPLE_BITS-1:0]                  o_lower_limit,
    output logic [SAMPLE_BITS-1:0]                  o_upper_limit,
    // Configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [taab_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [taab_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import taab_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int GSW   = SAMPLE_BITS + GROUP_SHIFT;
    localparam int CSW   = SAMPLE_BITS + CALIB_CNT_W;

    // Configuration registers.
    logic [7:0]  r_limit_margin;
    logic [7:0]  r_drift_pairs;
    logic [15:0] r_hold_ticks;

    // Front-end state.
    logic [GSW-1:0]         r_group_sum,   n_group_sum;
    logic [1:0]             r_group_count, n_group_count;
    logic [CSW-1:0]         r_calib_sum,   n_calib_sum;
    logic [CALIB_CNT_W-1:0] r_calib_count, n_calib_count;
    logic [SB-1:0]          r_last_point,  n_last_point;
    t_phase                 r_phase,       n_phase;

    // Result register.
    logic          r_out_valid;
    logic          r_point_valid;
    logic [SB-1:0] r_point_value;
    t_phase        r_out_phase;
    logic          r_alarm;
    logic [SB-1:0] r_baseline;
    logic [SB-1:0] r_lower;
    logic [SB-1:0] r_upper;

    logic           in_acc;
    t_cmd           cmd;
    logic [GSW-1:0] group_add;
    logic [SB-1:0]  point;
    logic           point_done;
    logic [CSW-1:0] calib_add;
    logic           calib_done;
    logic           in_calib;
    logic           in_check;
    t_trk_ctl       trk_ctl;
    logic           alarm_nxt;
    logic [SB-1:0]  base_nxt;
    logic [SB-1:0]  low_nxt;
    logic [SB-1:0]  high_nxt;

    // Handshakes: the result register empties or is being taken.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;

    // Point averaging and calibration sums.
    assign cmd        = t_cmd'(i_command);
    assign group_add  = r_group_sum + GSW'(i_sample_value);
    assign point      = group_add[GSW-1:GROUP_SHIFT];
    assign point_done = in_acc && (cmd == CMD_SAMPLE) && (r_group_count == GROUP_LAST);
    assign calib_add  = r_calib_sum + CSW'(point);
    assign calib_done = point_done && in_calib && (r_calib_count == CALIB_LAST);

    // Phase next state.
    always_comb begin
        n_phase = r_phase;
        if (in_acc && (cmd == CMD_START)) begin
            n_phase = PH_CALIB;
        end else if (calib_done) begin
            n_phase = PH_CHECK;
        end
    end

    // Phase decoded outputs.
    always_comb begin
        in_calib = 1'b0;
        in_check = 1'b0;
        case (r_phase)
            PH_CALIB: in_calib = 1'b1;
            PH_CHECK: in_check = 1'b1;
            default:  ;
        endcase
    end

    // Group and calibration accumulator updates.
    always_comb begin
        n_group_sum   = r_group_sum;
        n_group_count = r_group_count;
        n_calib_sum   = r_calib_sum;
        n_calib_count = r_calib_count;
        n_last_point  = r_last_point;
        if (in_acc) begin
            case (cmd)
                CMD_SAMPLE: begin
                    if (r_group_count == GROUP_LAST) begin
                        n_group_sum   = '0;
                        n_group_count = '0;
                        n_last_point  = point;
                        if (in_calib) begin
                            if (r_calib_count == CALIB_LAST) begin
                                n_calib_sum   = '0;
                                n_calib_count = '0;
                            end else begin
                                n_calib_sum   = calib_add;
                                n_calib_count = r_calib_count + CALIB_CNT_W'(1);
                            end
                        end
                    end else begin
                        n_group_sum   = group_add;
                        n_group_count = r_group_count + 2'd1;
                    end
                end
                CMD_START: begin
                    n_calib_sum   = '0;
                    n_calib_count = '0;
                end
                default: ;
            endcase
        end
    end

    // Strobes to the tracker.
    always_comb begin
        trk_ctl.point_chk = point_done && in_check;
        trk_ctl.load_base = calib_done;
        trk_ctl.tick      = in_acc && (cmd == CMD_TICK);
    end

    taab_track #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (trk_ctl),
        .i_point        (point),
        .i_calib_base   (calib_add[CSW-1:CALIB_CNT_W]),
        .i_limit_margin (r_limit_margin),
        .i_drift_pairs  (r_drift_pairs),
        .i_hold_ticks   (r_hold_ticks),
        .o_alarm_nxt    (alarm_nxt),
        .o_base_nxt     (base_nxt),
        .o_low_nxt      (low_nxt),
        .o_high_nxt     (high_nxt)
    );

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_margin <= MARGIN_RESET;
            r_drift_pairs  <= PAIRS_RESET;
            r_hold_ticks   <= HOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LIMIT_MARGIN: r_limit_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_DRIFT_PAIRS:  r_drift_pairs  <= i_cfg_data[PAIRS_W-1:0];
                CFG_HOLD_TICKS:   r_hold_ticks   <= i_cfg_data[HOLD_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front-end state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_sum   <= '0;
            r_group_count <= '0;
            r_calib_sum   <= '0;
            r_calib_count <= '0;
            r_last_point  <= '0;
            r_phase       <= PH_WAIT;
        end else begin
            r_group_sum   <= n_group_sum;
            r_group_count <= n_group_count;
            r_calib_sum   <= n_calib_sum;
            r_calib_count <= n_calib_count;
            r_last_point  <= n_last_point;
            r_phase       <= n_phase;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload: state as it stands after this transaction.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_point_valid <= point_done;
            r_point_value <= n_last_point;
            r_out_phase   <= n_phase;
            r_alarm       <= alarm_nxt;
            r_baseline    <= base_nxt;
            r_lower       <= low_nxt;
            r_upper       <= high_nxt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_valid = r_point_valid;
    assign o_point_value = r_point_value;
    assign o_phase       = r_out_phase;
    assign o_alarm       = r_alarm;
    assign o_baseline    = r_baseline;
    assign o_lower_limit = r_lower;
    assign o_upper_limit = r_upper;

endmodule

`default_nettype wire

// ===== rtl/taab_track.sv =====
// Baseline, limit, drift and alarm tracking for the tension alarm.
`default_nettype none

module taab_track #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire taab_pkg::t_trk_ctl        i_ctl,
    input  wire logic [SAMPLE_BITS-1:0]    i_point,
    input  wire logic [SAMPLE_BITS-1:0]    i_calib_base,
    input  wire logic [7:0]                i_limit_margin,
    input  wire logic [7:0]                i_drift_pairs,
    input  wire logic [15:0]               i_hold_ticks,
    output logic                           o_alarm_nxt,
    output logic [SAMPLE_BITS-1:0]         o_base_nxt,
    output logic [SAMPLE_BITS-1:0]         o_low_nxt,
    output logic [SAMPLE_BITS-1:0]         o_high_nxt
);
    import taab_pkg::*;

    localparam int                   SB   = SAMPLE_BITS;
    localparam int                   SW   = SAMPLE_BITS + 1;
    localparam logic [SB-1:0]        SMAX = {SB{1'b1}};

    // Lower limit: baseline minus margin, saturating at zero.
    function automatic logic [SB-1:0] f_low(input logic [SB-1:0] b, input logic [7:0] m);
        logic [SW-1:0] bw;
        logic [SW-1:0] mw;
        bw = {1'b0, b};
        mw = SW'(m);
        f_low = (bw > mw) ? SB'(bw - mw) : '0;
    endfunction

    // Upper limit: baseline plus margin, clamped to the sample range.
    function automatic logic [SB-1:0] f_high(input logic [SB-1:0] b, input logic [7:0] m);
        logic [SW-1:0] sum;
        sum = {1'b0, b} + SW'(m);
        f_high = (sum > {1'b0, SMAX}) ? SMAX : sum[SB-1:0];
    endfunction

    logic [SB-1:0] r_base,     n_base;
    logic [SB-1:0] r_low,      n_low;
    logic [SB-1:0] r_high,     n_high;
    logic [SB:0]   r_pair_sum, n_pair_sum;
    logic          r_pair_cnt, n_pair_cnt;
    logic [7:0]    r_drift,    n_drift;
    logic [3:0]    r_hist,     n_hist;
    logic [15:0]   r_timer,    n_timer;
    logic          r_alarm,    n_alarm;

    // Next state of the tracker for one transaction.
    always_comb begin
        logic          in_lim;
        logic [SB:0]   psum;
        logic [SB-1:0] avg;
        logic [7:0]    dc;
        logic [SB-1:0] base_dn;
        logic [SB-1:0] base_up;

        n_base     = r_base;
        n_low      = r_low;
        n_high     = r_high;
        n_pair_sum = r_pair_sum;
        n_pair_cnt = r_pair_cnt;
        n_drift    = r_drift;
        n_hist     = r_hist;
        n_timer    = r_timer;
        n_alarm    = r_alarm;

        in_lim  = (i_point >= r_low) && (i_point <= r_high);
        psum    = r_pair_sum + SW'(i_point);
        avg     = psum[SB:1];
        dc      = r_drift + 8'd1;
        base_dn = r_base - SB'(1);
        base_up = r_base + SB'(1);

        // Hold timer counts ticks and saturates.
        if (i_ctl.tick && (r_timer != '1)) begin
            n_timer = r_timer + 16'd1;
        end

        // End of calibration loads a fresh baseline.
        if (i_ctl.load_base) begin
            n_base     = i_calib_base;
            n_low      = f_low(i_calib_base, i_limit_margin);
            n_high     = f_high(i_calib_base, i_limit_margin);
            n_pair_sum = '0;
            n_pair_cnt = 1'b0;
        end

        // Check-phase point: pair averaging, drift tracking and excursion history.
        if (i_ctl.point_chk) begin
            n_hist = {r_hist[2:0], 1'b0};
            if (in_lim) begin
                if (r_pair_cnt) begin
                    if ({1'b0, r_base} > ({1'b0, avg} + SW'(1))) begin
                        n_drift = dc;
                        if (dc >= i_drift_pairs) begin
                            if (r_base != '0) begin
                                n_base = base_dn;
                                n_low  = f_low(base_dn, i_limit_margin);
                                if (r_high != '0) begin
                                    n_high = r_high - SB'(1);
                                end
                            end
                            n_drift = '0;
                        end
                    end else if ({1'b0, avg} > ({1'b0, r_base} + SW'(1))) begin
                        n_drift = dc;
                        if (dc >= i_drift_pairs) begin
                            if (r_base != SMAX) begin
                                n_base = base_up;
                                n_low  = f_low(base_up, i_limit_margin);
                                if (r_high != SMAX) begin
                                    n_high = r_high + SB'(1);
                                end
                            end
                            n_drift = '0;
                        end
                    end
                    n_pair_sum = '0;
                    n_pair_cnt = 1'b0;
                end else begin
                    n_pair_sum = psum;
                    n_pair_cnt = 1'b1;
                end
            end else begin
                n_hist = {r_hist[2:0], 1'b1};
            end

            // Four excursions in a row re-center on the point and raise the alarm.
            if (n_hist == HIST_ALL_OUT) begin
                n_alarm    = 1'b1;
                n_timer    = '0;
                n_base     = i_point;
                n_low      = f_low(i_point, i_limit_margin);
                n_high     = f_high(i_point, i_limit_margin);
                n_pair_sum = '0;
                n_pair_cnt = 1'b0;
                n_drift    = '0;
            end else if ((n_hist == HIST_ALL_IN) && (r_timer > i_hold_ticks)) begin
                n_alarm = 1'b0;
            end
        end
    end

    // Tracker state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_low      <= '0;
            r_high     <= '0;
            r_pair_sum <= '0;
            r_pair_cnt <= 1'b0;
            r_drift    <= '0;
            r_hist     <= '0;
            r_timer    <= '0;
            r_alarm    <= 1'b0;
        end else begin
            r_base     <= n_base;
            r_low      <= n_low;
            r_high     <= n_high;
            r_pair_sum <= n_pair_sum;
            r_pair_cnt <= n_pair_cnt;
            r_drift    <= n_drift;
            r_hist     <= n_hist;
            r_timer    <= n_timer;
            r_alarm    <= n_alarm;
        end
    end

    assign o_alarm_nxt = n_alarm;
    assign o_base_nxt  = n_base;
    assign o_low_nxt   = n_low;
    assign o_high_nxt  = n_high;

endmodule

`default_nettype wire

// ===== rtl/taab_checker.sv =====
// Port-level assertion checker for the tension alarm, bound to the top level.
`default_nettype none
`include "tension_alarm_adaptive_baseline_top_macros.svh"

module taab_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               o_in_ready,
    input  wire logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [1:0]                         o_phase,
    input  wire logic                               o_alarm,
    input  wire logic [SAMPLE_BITS-1:0]             o_baseline,
    input  wire logic [SAMPLE_BITS-1:0]             o_lower_limit,
    input  wire logic [SAMPLE_BITS-1:0]             o_upper_limit
);
    import taab_pkg::*;

    // A pending result stays offered until the transaction completes.
    `TAAB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped before it was taken")

    // An empty result register never blocks the input side.
    `TAAB_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty result register")

    // The baseline always sits between its limits.
    `TAAB_ASSERT_NOW(a_limits_order, i_clk, i_rst_n, o_out_valid, (o_lower_limit <= o_baseline) && (o_baseline <= o_upper_limit), "baseline outside its limits")

    // Before any calibration the alarm is low and no baseline exists.
    `TAAB_ASSERT_NOW(a_wait_quiet, i_clk, i_rst_n, o_out_valid && (o_phase == PH_WAIT), !o_alarm && (o_baseline == '0), "alarm or baseline set while waiting")

    // The first cycle after reset shows no result.
    `TAAB_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid, "result valid right after reset")

endmodule

bind tension_alarm_adaptive_baseline_top taab_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_taab_checker (.*);

`default_nettype wire

// ===== tb/tension_alarm_adaptive_baseline_checker.sv =====
// Checker that predicts and compares the results of the tension alarm block.
`timescale 1ns / 100ps

module tension_alarm_adaptive_baseline_checker #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input channel as seen by the block
    input  wire logic                             i_in_valid,
    input  wire logic                             i_in_ready,
    input  wire logic [1:0]                       i_command,
    input  wire logic [SAMPLE_BITS-1:0]           i_sample_value,
    // Result channel as seen by the block
    input  wire logic                             i_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic                             i_point_valid,
    input  wire logic [SAMPLE_BITS-1:0]           i_point_value,
    input  wire logic [1:0]                       i_phase,
    input  wire logic                             i_alarm,
    input  wire logic [SAMPLE_BITS-1:0]           i_baseline,
    input  wire logic [SAMPLE_BITS-1:0]           i_lower_limit,
    input  wire logic [SAMPLE_BITS-1:0]           i_upper_limit,
    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [taab_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [taab_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Totals handed to the testbench top
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_result_count,
    output int                                    o_point_count,
    output int                                    o_recenter_count
);
    import taab_pkg::*;

    localparam int SB           = SAMPLE_BITS;
    localparam int SMAX         = (1 << SAMPLE_BITS) - 1;
    localparam int CALIB_POINTS = 32;

    // One result transaction of the block.
    typedef struct packed {
        logic          point_valid;
        logic [SB-1:0] point_value;
        t_phase        phase;
        logic          alarm;
        logic [SB-1:0] baseline;
        logic [SB-1:0] lower_limit;
        logic [SB-1:0] upper_limit;
    } t_status;

    // Configuration copy.
    logic [MARGIN_W-1:0] margin_cfg;
    logic [PAIRS_W-1:0]  pairs_cfg;
    logic [HOLD_W-1:0]   hold_cfg;

    // Predicted state of the block.
    logic [SB+1:0] group_sum;
    logic [1:0]    group_cnt;
    logic [SB+4:0] calib_sum;
    logic [4:0]    calib_cnt;
    logic [SB:0]   pair_sum;
    logic          pair_cnt;
    logic [7:0]    drift_cnt;
    logic [SB-1:0] base_q;
    logic [SB-1:0] low_q;
    logic [SB-1:0] high_q;
    logic [3:0]    out_hist;
    logic [15:0]   hold_timer;
    logic          alarm_q;
    t_phase        phase_q;
    logic [SB-1:0] last_point;

    t_status pending_status[$];
    int      fail_count     = 0;
    int      result_count   = 0;
    int      point_count    = 0;
    int      recenter_count = 0;
    int      pending_count  = 0;

    assign o_fail_count     = fail_count;
    assign o_pending        = pending_count;
    assign o_result_count   = result_count;
    assign o_point_count    = point_count;
    assign o_recenter_count = recenter_count;

    // Lower limit for a baseline, saturating at zero.
    function automatic logic [SB-1:0] lower_of(input logic [SB-1:0] base);
        return (base > SB'(margin_cfg)) ? base - SB'(margin_cfg) : '0;
    endfunction

    // Both limits around the current baseline, the upper one clamped to the sample range.
    function automatic void center_limits();
        int sum;
        sum    = int'(base_q) + int'(margin_cfg);
        low_q  = lower_of(base_q);
        high_q = SB'((sum > SMAX) ? SMAX : sum);
    endfunction

    // Check-phase handling of one averaged point.
    function automatic void judge_point(input logic [SB-1:0] pt);
        int avg;
        out_hist = {out_hist[2:0], 1'b0};
        if (pt >= low_q && pt <= high_q) begin
            pair_sum = pair_sum + (SB+1)'(pt);
            if (pair_cnt) begin
                avg = int'(pair_sum >> 1);
                if (int'(base_q) > avg + 1) begin
                    drift_cnt = drift_cnt + 8'd1;
                    if (drift_cnt >= pairs_cfg) begin
                        if (base_q != '0) begin
                            base_q = base_q - SB'(1);
                            low_q  = lower_of(base_q);
                            if (high_q != '0) high_q = high_q - SB'(1);
                        end
                        drift_cnt = '0;
                    end
                end else if (avg > int'(base_q) + 1) begin
                    drift_cnt = drift_cnt + 8'd1;
                    if (drift_cnt >= pairs_cfg) begin
                        if (int'(base_q) < SMAX) begin
                            base_q = base_q + SB'(1);
                            low_q  = lower_of(base_q);
                            if (int'(high_q) < SMAX) high_q = high_q + SB'(1);
                        end
                        drift_cnt = '0;
                    end
                end
                pair_sum = '0;
                pair_cnt = 1'b0;
            end else begin
                pair_cnt = 1'b1;
            end
        end else begin
            out_hist[0] = 1'b1;
        end

        // Four points in a row outside the limits re-center everything on this point.
        if (out_hist == 4'hF) begin
            alarm_q    = 1'b1;
            hold_timer = '0;
            base_q     = pt;
            center_limits();
            pair_sum   = '0;
            pair_cnt   = 1'b0;
            drift_cnt  = '0;
            recenter_count++;
        end else if (out_hist == 4'h0) begin
            if (hold_timer > hold_cfg) alarm_q = 1'b0;
        end
    endfunction

    // Advances the predicted state by one input transaction and returns its status.
    function automatic t_status next_status(input logic [1:0] cmd, input logic [SB-1:0] smp);
        t_status       st;
        logic [SB-1:0] pt;
        logic          done;
        done = 1'b0;
        case (cmd)
            CMD_SAMPLE: begin
                group_sum = group_sum + (SB+2)'(smp);
                if (group_cnt == 2'd3) begin
                    pt         = group_sum[SB+1:2];
                    group_sum  = '0;
                    group_cnt  = '0;
                    last_point = pt;
                    done       = 1'b1;
                    if (phase_q == PH_CALIB) begin
                        calib_sum = calib_sum + (SB+5)'(pt);
                        if (calib_cnt == 5'(CALIB_POINTS - 1)) begin
                            base_q = calib_sum[SB+4:5];
                            center_limits();
                            calib_sum = '0;
                            calib_cnt = '0;
                            pair_sum  = '0;
                            pair_cnt  = 1'b0;
                            phase_q   = PH_CHECK;
                        end else begin
                            calib_cnt = calib_cnt + 5'd1;
                        end
                    end else if (phase_q == PH_CHECK) begin
                        judge_point(pt);
                    end
                end else begin
                    group_cnt = group_cnt + 2'd1;
                end
            end
            CMD_TICK: begin
                if (hold_timer != 16'hFFFF) hold_timer = hold_timer + 16'd1;
            end
            CMD_START: begin
                phase_q   = PH_CALIB;
                calib_sum = '0;
                calib_cnt = '0;
            end
            default: begin
                // The unused command changes nothing.
            end
        endcase
        st.point_valid = done;
        st.point_value = last_point;
        st.phase       = phase_q;
        st.alarm       = alarm_q;
        st.baseline    = base_q;
        st.lower_limit = low_q;
        st.upper_limit = high_q;
        return st;
    endfunction

    // Reports one field that differs.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Watch all three channels on each rising edge.
    always @(posedge i_clk) begin : watch
        t_status want;
        if (!i_rst_n) begin
            margin_cfg = MARGIN_RESET;
            pairs_cfg  = PAIRS_RESET;
            hold_cfg   = HOLD_RESET;
            group_sum  = '0;
            group_cnt  = '0;
            calib_sum  = '0;
            calib_cnt  = '0;
            pair_sum   = '0;
            pair_cnt   = 1'b0;
            drift_cnt  = '0;
            base_q     = '0;
            low_q      = '0;
            high_q     = '0;
            out_hist   = '0;
            hold_timer = '0;
            alarm_q    = 1'b0;
            phase_q    = PH_WAIT;
            last_point = '0;
            pending_status.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LIMIT_MARGIN: margin_cfg = i_cfg_data[MARGIN_W-1:0];
                    CFG_DRIFT_PAIRS:  pairs_cfg  = i_cfg_data[PAIRS_W-1:0];
                    CFG_HOLD_TICKS:   hold_cfg   = i_cfg_data[HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Result transactions against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (pending_status.size() == 0) begin
                    $error("result transaction arrived with no input transaction waiting");
                    fail_count++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("point_valid", int'(want.point_valid), int'(i_point_valid));
                    check_field("point_value", int'(want.point_value), int'(i_point_value));
                    check_field("phase", int'(want.phase), int'(i_phase));
                    check_field("alarm", int'(want.alarm), int'(i_alarm));
                    check_field("baseline", int'(want.baseline), int'(i_baseline));
                    check_field("lower_limit", int'(want.lower_limit), int'(i_lower_limit));
                    check_field("upper_limit", int'(want.upper_limit), int'(i_upper_limit));
                end
            end

            // Input transactions each cause one result.
            if (i_in_valid && i_in_ready) begin
                want = next_status(i_command, i_sample_value);
                if (want.point_valid) point_count++;
                pending_status.push_back(want);
            end
        end
        pending_count = pending_status.size();
    end

endmodule

// ===== tb/tension_alarm_adaptive_baseline_top_tb.sv =====
// Testbench top for the tension alarm block: stimulus, idling and the final verdict.
`timescale 1ns / 100ps

module tension_alarm_adaptive_baseline_top_tb;
    import taab_pkg::*;

    localparam int             SW             = 10;
    localparam int             SMAX           = (1 << SW) - 1;
    localparam int             N_PHASES       = 6;
    localparam int             DIRECTED_ITEMS = 25;
    localparam int             PHASE_ITEMS    = 150;
    localparam int             WATCHDOG_LIMIT = 2000;
    localparam logic [1:0]     CMD_UNUSED     = 2'd3;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_command      = CMD_SAMPLE;
    logic [SW-1:0]         i_sample_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic                  o_point_valid;
    logic [SW-1:0]         o_point_value;
    logic [1:0]            o_phase;
    logic                  o_alarm;
    logic [SW-1:0]         o_baseline;
    logic [SW-1:0]         o_lower_limit;
    logic [SW-1:0]         o_upper_limit;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = CFG_LIMIT_MARGIN;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    int fail_count;
    int pending_results;
    int result_count;
    int point_count;
    int recenter_count;

    int items_sent   = 0;
    int calibrations = 0;
    int settings     = 1;
    int level        = 512;
    int drift_dir    = 1;
    int margin_now   = 50;
    int quiet_cycles = 0;
    bit gap_on       = 1'b1;
    bit stall_on     = 1'b1;

    always #2 i_clk = ~i_clk;

    tension_alarm_adaptive_baseline_top #(
        .SAMPLE_BITS (SW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_point_valid  (o_point_valid),
        .o_point_value  (o_point_value),
        .o_phase        (o_phase),
        .o_alarm        (o_alarm),
        .o_baseline     (o_baseline),
        .o_lower_limit  (o_lower_limit),
        .o_upper_limit  (o_upper_limit),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tension_alarm_adaptive_baseline_checker #(
        .SAMPLE_BITS (SW)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_sample_value   (i_sample_value),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_point_valid    (o_point_valid),
        .i_point_value    (o_point_value),
        .i_phase          (o_phase),
        .i_alarm          (o_alarm),
        .i_baseline       (o_baseline),
        .i_lower_limit    (o_lower_limit),
        .i_upper_limit    (o_upper_limit),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results),
        .o_result_count   (result_count),
        .o_point_count    (point_count),
        .o_recenter_count (recenter_count)
    );

    // Receiver side: ready drops in random bursts while stalling is enabled.
    always begin
        @(negedge i_clk);
        if (stall_on && $urandom_range(0, 5) == 0) begin
            i_out_ready = 1'b0;
            repeat ($urandom_range(1, 18)) begin
                if (stall_on) @(negedge i_clk);
            end
        end
        i_out_ready = 1'b1;
        repeat ($urandom_range(0, 24)) @(negedge i_clk);
    end

    // The run ends if no transaction of any channel happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [SW-1:0] clamp_sample(input int v);
        return SW'((v < 0) ? 0 : ((v > SMAX) ? SMAX : v));
    endfunction

    // A level far enough from the given one to fall outside the current limits.
    function automatic int far_level(input int lvl);
        int gap;
        bit go_up;
        gap   = margin_now + 6;
        go_up = (lvl - gap < 0) || ((lvl + gap <= SMAX) && $urandom_range(0, 1) == 1);
        if (go_up && lvl + gap <= SMAX) begin
            return ($urandom_range(0, 3) == 0) ? SMAX : $urandom_range(lvl + gap, SMAX);
        end else if (lvl - gap >= 0) begin
            return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, lvl - gap);
        end
        return (lvl < SMAX / 2) ? SMAX : 0;
    endfunction

    // Calibration levels lean toward both ends so that the limits saturate.
    function automatic int pick_level();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, 40);
            1:       return $urandom_range(SMAX - 40, SMAX);
            default: return $urandom_range(0, SMAX);
        endcase
    endfunction

    // Sends one input transaction; entered and left at a falling edge.
    task automatic drive_item(input logic [1:0] cmd, input logic [SW-1:0] smp);
        if (gap_on && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_sample_value = smp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Four samples around a level, with ticks and an odd unused command in between.
    task automatic drive_point(input int lvl, input int spread);
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 7) == 0) drive_item(CMD_TICK, SW'($urandom));
            if ($urandom_range(0, 79) == 0) drive_item(CMD_UNUSED, SW'($urandom));
            drive_item(CMD_SAMPLE,
                       clamp_sample(lvl + int'($urandom_range(0, 2 * spread)) - spread));
        end
    endtask

    // Holds off the sender until every result has been taken.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes all three registers; the unused upper byte of the narrow ones is random.
    task automatic set_config(input int margin, input int pairs, input int hold);
        write_reg(CFG_LIMIT_MARGIN, {8'($urandom), 8'(margin)});
        write_reg(CFG_DRIFT_PAIRS, {8'($urandom), 8'(pairs)});
        write_reg(CFG_HOLD_TICKS, 16'(hold));
        i_cfg_valid = 1'b0;
        margin_now  = margin;
        settings++;
    endtask

    // A start command and 32 points; sometimes a restart cuts an earlier attempt short.
    task automatic run_calibration(input int lvl);
        drive_item(CMD_START, SW'($urandom));
        calibrations++;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 31)) drive_point(lvl, 40);
            drive_item(CMD_START, SW'($urandom));
        end
        repeat (32) drive_point(lvl, 4);
    endtask

    // Check-phase traffic: a slowly drifting level, step changes, ticks and noise.
    task automatic run_tracking(input int stop_at);
        int pick;
        int far;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                if ($urandom_range(0, 2) == 0) level = int'(clamp_sample(level + drift_dir));
                if ($urandom_range(0, 30) == 0) drift_dir = -drift_dir;
                drive_point(level, 3);
            end else if (pick < 72) begin
                // A step change long enough to raise the alarm; the level follows it.
                far = far_level(level);
                repeat ($urandom_range(4, 6)) drive_point(far, 2);
                level = far;
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 40)) drive_item(CMD_TICK, SW'($urandom));
            end else if (pick < 86) begin
                // A short excursion, too few points for the alarm.
                repeat ($urandom_range(1, 3)) drive_point(far_level(level), 2);
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 4)) drive_item(CMD_SAMPLE, SW'($urandom));
                if ($urandom_range(0, 1) == 0) drive_item(CMD_UNUSED, SW'($urandom));
            end else if (pick < 97) begin
                // The sender pauses for the results while gaps are enabled, never in the final full-rate part.
                if (gap_on) wait_drained();
            end else begin
                // Start while checking: calibrate again around a fresh level.
                level = pick_level();
                run_calibration(level);
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: points while waiting, sample extremes, every command,
        // the unused command, and a start while already calibrating.
        repeat (4) drive_item(CMD_SAMPLE, '0);
        repeat (4) drive_item(CMD_SAMPLE, '1);
        drive_item(CMD_TICK, '1);
        drive_item(CMD_UNUSED, '1);
        drive_item(CMD_UNUSED, '0);
        drive_item(CMD_START, '0);
        repeat (4) drive_item(CMD_SAMPLE, 10'h2AA);
        drive_item(CMD_START, '1);
        repeat (4) drive_item(CMD_SAMPLE, 10'h155);
        drive_item(CMD_TICK, '0);

        // Random part in phases, each with its own register setting.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    // Reset values stay in force.
                end
                1: set_config(0, 1, 0);
                2: set_config(255, 255, 65535);
                3: set_config($urandom_range(8, 40), 0, $urandom_range(0, 8));
                4: set_config($urandom_range(0, 255), $urandom_range(1, 6),
                              $urandom_range(0, 40));
                default: set_config($urandom_range(10, 80), $urandom_range(1, 255),
                                    $urandom_range(0, 200));
            endcase
            if (p == N_PHASES - 1) begin
                gap_on   = 1'b0;
                stall_on = 1'b0;
            end else begin
                gap_on   = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if (p == 0 || $urandom_range(0, 1) == 1) begin
                level = pick_level();
                run_calibration(level);
            end
            run_tracking(DIRECTED_ITEMS + (p + 1) * PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(negedge i_clk);

        $display("Covered %0d input and %0d result transactions under %0d register settings.",
                 items_sent, result_count, settings);
        $display("This included %0d calibrations, %0d averaged points and %0d alarm re-centers.",
                 calibrations, point_count, recenter_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
